### rtl/mlpl_pkg.sv
// Package of the multilevel IPv6 prefix lookup block.
// Holds table geometry, field widths, level and kind codes and the control structs.
// Has no dependencies; every other file of the block but mlpl_ram imports it.
`timescale 1ns / 1ps

package mlpl_pkg;

  localparam int unsigned TABLE_INDEX_BITS = 16;
  localparam int unsigned HOP_BITS = 16;

  localparam int unsigned ADDR_BITS = 64;
  localparam int unsigned SEL_BITS = 3;
  localparam int unsigned WIDX_BITS = 16;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned ENTRY_BITS = VALUE_BITS + 1;
  localparam int unsigned LEVEL_BITS = 3;
  localparam int unsigned NUM_LEVELS = 6;
  localparam int unsigned WIDE_BITS = 32;

  localparam int unsigned IN_DATA_BITS = 104;
  localparam int unsigned OUT_DATA_BITS = 24;

  localparam int unsigned TABLE_DEPTH = 1 << TABLE_INDEX_BITS;
  localparam logic [WIDE_BITS-1:0] TABLE_DEPTH_W = WIDE_BITS'(TABLE_DEPTH);
  localparam logic [VALUE_BITS-1:0] HOP_MASK = VALUE_BITS'((32'd1 << HOP_BITS) - 32'd1);

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [LEVEL_BITS-1:0] LVL_16 = 3'd0;
  localparam logic [LEVEL_BITS-1:0] LVL_24 = 3'd1;
  localparam logic [LEVEL_BITS-1:0] LVL_32 = 3'd2;
  localparam logic [LEVEL_BITS-1:0] LVL_40 = 3'd3;
  localparam logic [LEVEL_BITS-1:0] LVL_48 = 3'd4;
  localparam logic [LEVEL_BITS-1:0] LVL_64 = 3'd5;

  typedef struct packed {
    logic write;
    logic start;
    logic read;
    logic hit;
    logic advance;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic start_err;
    logic done;
    logic child_err;
    logic out_busy;
  } dp_sts_t;

endpackage

### rtl/mlpl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for every lookup table of the block; no package dependency.
`timescale 1ns / 1ps

module mlpl_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mlpl_ctrl.sv
// Controller state machine of the prefix lookup: sequences table writes and level walks.
// Depends on mlpl_pkg for the command and status structs and the kind codes.
`timescale 1ns / 1ps

module mlpl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  output logic             in_ready_o,
  input  mlpl_pkg::dp_sts_t sts_i,
  output mlpl_pkg::dp_cmd_t cmd_o
);

  import mlpl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.write = accept && (in_kind_i == KIND_WRITE);
    cmd_o.start = accept && (in_kind_i == KIND_LOOKUP);
    case (state_q)
      ST_READ: begin
        cmd_o.read = 1'b1;
      end
      ST_CHECK: begin
        cmd_o.hit = sts_i.done;
        cmd_o.advance = !sts_i.done;
      end
      ST_FINISH: begin
        cmd_o.emit = !sts_i.out_busy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && (in_kind_i == KIND_LOOKUP)) begin
            state_q <= sts_i.start_err ? ST_FINISH : ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (sts_i.done || sts_i.child_err) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_READ;
          end
        end
        ST_FINISH: begin
          if (!sts_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/mlpl_datapath.sv
// Datapath of the prefix lookup: the six level tables, index arithmetic and result register.
// Depends on mlpl_pkg and instantiates mlpl_ram once per level.
`timescale 1ns / 1ps

module mlpl_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [mlpl_pkg::IN_DATA_BITS-1:0]    in_data_i,
  input  mlpl_pkg::dp_cmd_t                    cmd_i,
  output mlpl_pkg::dp_sts_t                    sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [mlpl_pkg::OUT_DATA_BITS-1:0]   out_data_o,
  output logic                                 out_err_o
);

  import mlpl_pkg::*;

  logic [ADDR_BITS-1:0]  in_addr;
  logic [SEL_BITS-1:0]   in_sel;
  logic [WIDX_BITS-1:0]  in_widx;
  logic                  in_leaf;
  logic [VALUE_BITS-1:0] in_value;

  logic [WIDE_BITS-1:0]        start_idx_w;
  logic [WIDE_BITS-1:0]        widx_w;
  logic                        widx_ok;
  logic [TABLE_INDEX_BITS-1:0] waddr;

  logic [ADDR_BITS-1:0]        addr_q;
  logic [TABLE_INDEX_BITS-1:0] idx_q;
  logic [LEVEL_BITS-1:0]       level_q;
  logic [VALUE_BITS-1:0]       res_hop_q;
  logic                        res_err_q;

  logic                        out_valid_q;
  logic [VALUE_BITS-1:0]       out_hop_q;
  logic [LEVEL_BITS-1:0]       out_level_q;
  logic                        out_err_q;

  logic [ENTRY_BITS-1:0] rdata [NUM_LEVELS];
  logic [ENTRY_BITS-1:0] entry;
  logic [VALUE_BITS-1:0] entry_value;
  logic [7:0]            next_byte;
  logic [WIDE_BITS-1:0]  child_idx_w;
  logic                  child_err;
  logic [VALUE_BITS-1:0] level64_rdata;

  assign in_addr  = in_data_i[63:0];
  assign in_sel   = in_data_i[66:64];
  assign in_widx  = in_data_i[82:67];
  assign in_leaf  = in_data_i[83];
  assign in_value = in_data_i[99:84];

  assign start_idx_w = WIDE_BITS'(in_addr[63:48]);
  assign widx_w = WIDE_BITS'(in_widx);
  assign widx_ok = (widx_w < TABLE_DEPTH_W);
  assign waddr = widx_w[TABLE_INDEX_BITS-1:0];

  for (genvar g = 0; g < NUM_LEVELS - 1; g++) begin : g_level
    mlpl_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
    ) u_table (
      .clk_i   (clk_i),
      .we_i    (cmd_i.write && widx_ok && (in_sel == LEVEL_BITS'(g))),
      .waddr_i (waddr),
      .wdata_i ({in_leaf, in_value}),
      .re_i    (cmd_i.read && (level_q == LEVEL_BITS'(g))),
      .raddr_i (idx_q),
      .rdata_o (rdata[g])
    );
  end

  mlpl_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table64 (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write && widx_ok && (in_sel == LVL_64)),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .re_i    (cmd_i.read && (level_q == LVL_64)),
    .raddr_i (idx_q),
    .rdata_o (level64_rdata)
  );

  assign rdata[NUM_LEVELS-1] = {1'b0, level64_rdata};

  always_comb begin
    entry = '0;
    if (level_q < LEVEL_BITS'(NUM_LEVELS)) begin
      entry = rdata[level_q];
    end
  end

  assign entry_value = entry[VALUE_BITS-1:0];

  always_comb begin
    case (level_q)
      LVL_16:  next_byte = addr_q[47:40];
      LVL_24:  next_byte = addr_q[39:32];
      LVL_32:  next_byte = addr_q[31:24];
      LVL_40:  next_byte = addr_q[23:16];
      default: next_byte = '0;
    endcase
  end

  always_comb begin
    if (level_q == LVL_48) begin
      child_idx_w = {entry_value, addr_q[15:0]};
    end else begin
      child_idx_w = WIDE_BITS'({entry_value, next_byte});
    end
  end

  assign child_err = (child_idx_w >= TABLE_DEPTH_W);

  assign sts_o.start_err = (start_idx_w >= TABLE_DEPTH_W);
  assign sts_o.done = (level_q == LVL_64) || entry[VALUE_BITS];
  assign sts_o.child_err = child_err;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q <= in_addr;
      idx_q <= start_idx_w[TABLE_INDEX_BITS-1:0];
      level_q <= LVL_16;
      res_hop_q <= '0;
      res_err_q <= sts_o.start_err;
    end else if (cmd_i.advance) begin
      idx_q <= child_idx_w[TABLE_INDEX_BITS-1:0];
      level_q <= level_q + LEVEL_BITS'(1);
      res_hop_q <= '0;
      res_err_q <= child_err;
    end else if (cmd_i.hit) begin
      res_hop_q <= entry_value & HOP_MASK;
      res_err_q <= 1'b0;
    end
    if (cmd_i.emit) begin
      out_hop_q <= res_hop_q;
      out_level_q <= level_q;
      out_err_q <= res_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = OUT_DATA_BITS'({out_level_q, out_hop_q});
  assign out_err_o = out_err_q;

endmodule

### rtl/multilevel_ipv6_prefix_lookup_top.sv
// Top level of the multilevel IPv6 prefix lookup block.
// Depends on mlpl_pkg; joins the controller mlpl_ctrl and the datapath mlpl_datapath.
`timescale 1ns / 1ps

// Usage: every request on the slave stream is either a table write (tuser = 1) or a
// lookup of the upper 64 address bits (tuser = 0). A write stores one entry into the
// table chosen by table_select and produces no result. A lookup walks the level tables
// from level 16 down, one table per level, and yields one result on the master stream.
// Each level takes a read state, which reads the table memory, and a check state, which
// checks the entry and forms the next index; the finished result then goes into the
// output register. An index that falls out of the table depth ends the walk at once.
// A write is stored in the same cycle as it is accepted.
// The controller handles one request at a time; tready is high whenever it is idle,
// also while a finished result waits in the output register.
// If the receiver stalls, a finished lookup holds in the datapath until the output
// register is free, and no further request is accepted meanwhile.
// Reset clears the controller and the output valid flag; table contents are undefined
// until written, and an entry must be written before a lookup reads it.
module multilevel_ipv6_prefix_lookup_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // address[63:0], table_select[66:64], entry_index[82:67], entry_is_leaf[83],
  // entry_value[99:84], zero fill above.
  input  logic [mlpl_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // kind.
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // hop[15:0], resolved_level[18:16], zero fill above.
  output logic [mlpl_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // index_error.
  output logic                                m_axis_tuser
);

  import mlpl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mlpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlpl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for multilevel_ipv6_prefix_lookup_top.
// Keeps its own copy of the six level tables, predicts every lookup answer and checks
// each master-stream result in order; depends only on mlpl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import mlpl_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 12;
  localparam int ITEM_TARGET = 1400;
  localparam int MAX_IDLE = 13;
  localparam int STALL_CYCLES = 400;
  localparam int STALL_LOOKUPS = 30;
  localparam int SETTLE_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;
  localparam int POOL_SIZE = 16;

  // Table codes above level 64 select no table; writes to them are dropped.
  localparam logic [SEL_BITS-1:0] SEL_SPARE_A = 3'd6;
  localparam logic [SEL_BITS-1:0] SEL_SPARE_B = 3'd7;

  typedef struct packed {
    logic [VALUE_BITS-1:0] hop;
    logic [LEVEL_BITS-1:0] level;
    logic                  err;
  } answer_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic                     s_axis_tuser = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tuser;

  multilevel_ipv6_prefix_lookup_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  bit [ENTRY_BITS-1:0] route_tab [NUM_LEVELS][TABLE_DEPTH];
  bit                  route_written [NUM_LEVELS][TABLE_DEPTH];

  answer_t             answer_q [$];
  logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];
  int                  mismatch_cnt = 0;
  int                  sent_items = 0;
  int                  idle_cycles = 0;
  int                  rx_stall_len = 0;
  bit                  tx_idle_on = 1'b1;
  bit                  rx_idle_on = 1'b1;

  // Walks the trie for one address. Returns 0 when the walk would read an entry that
  // was never written, and then names that entry.
  function automatic bit walk_trie(input logic [ADDR_BITS-1:0] addr, output answer_t ans,
                                   output logic [LEVEL_BITS-1:0] miss_lvl,
                                   output logic [WIDX_BITS-1:0] miss_idx);
    logic [WIDE_BITS-1:0]  idx;
    logic [ENTRY_BITS-1:0] e;
    logic [LEVEL_BITS-1:0] lvl;
    ans = '0;
    miss_lvl = LVL_16;
    miss_idx = '0;
    idx = WIDE_BITS'(addr[63:48]);
    for (lvl = LVL_16; lvl <= LVL_64; lvl++) begin
      if (idx >= TABLE_DEPTH_W) begin
        ans.hop = '0;
        ans.level = lvl;
        ans.err = 1'b1;
        return 1'b1;
      end
      if (!route_written[lvl][idx[TABLE_INDEX_BITS-1:0]]) begin
        miss_lvl = lvl;
        miss_idx = idx[WIDX_BITS-1:0];
        return 1'b0;
      end
      e = route_tab[lvl][idx[TABLE_INDEX_BITS-1:0]];
      if (lvl == LVL_64 || e[VALUE_BITS]) begin
        ans.hop = e[VALUE_BITS-1:0] & HOP_MASK;
        ans.level = lvl;
        ans.err = 1'b0;
        return 1'b1;
      end
      if (lvl < LVL_48)
        idx = (WIDE_BITS'(e[VALUE_BITS-1:0]) << 8) + WIDE_BITS'(addr[(47 - 8 * lvl) -: 8]);
      else
        idx = (WIDE_BITS'(e[VALUE_BITS-1:0]) << 16) + WIDE_BITS'(addr[15:0]);
    end
    return 1'b1;
  endfunction

  function automatic logic [ADDR_BITS-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IN_DATA_BITS-1:0] pack_req(input logic [ADDR_BITS-1:0] addr,
                                                       input logic [SEL_BITS-1:0] sel,
                                                       input logic [WIDX_BITS-1:0] idx,
                                                       input logic leaf,
                                                       input logic [VALUE_BITS-1:0] val);
    return IN_DATA_BITS'({val, leaf, idx, sel, addr});
  endfunction

  // Reuses a recent address with some low bytes redrawn, so walks share deep paths.
  function automatic logic [ADDR_BITS-1:0] pick_addr();
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] keep;
    int                   cut;
    addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    cut = $urandom_range(0, 8);
    if (cut == 8) begin
      addr = {addr_pool[$urandom_range(0, POOL_SIZE - 1)][63:48], 48'(rand_addr())};
    end else begin
      keep = {ADDR_BITS{1'b1}} << (8 * cut);
      addr = (addr & keep) | (rand_addr() & ~keep);
    end
    addr_pool[$urandom_range(0, POOL_SIZE - 1)] = addr;
    return addr;
  endfunction

  task automatic apply_request(input logic kind, input logic [IN_DATA_BITS-1:0] data);
    logic [SEL_BITS-1:0]   sel;
    logic [WIDX_BITS-1:0]  idx;
    answer_t               ans;
    logic [LEVEL_BITS-1:0] miss_lvl;
    logic [WIDX_BITS-1:0]  miss_idx;
    sel = data[66:64];
    idx = data[82:67];
    if (kind == KIND_WRITE) begin
      if (sel <= LVL_64) begin
        if (sel == LVL_64)
          route_tab[sel][idx] = {1'b0, data[99:84]};
        else
          route_tab[sel][idx] = {data[83], data[99:84]};
        route_written[sel][idx] = 1'b1;
      end
    end else begin
      void'(walk_trie(data[ADDR_BITS-1:0], ans, miss_lvl, miss_idx));
      answer_q.push_back(ans);
    end
  endtask

  task automatic send_req(input logic kind, input logic [IN_DATA_BITS-1:0] data);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
    apply_request(kind, data);
  endtask

  task automatic write_entry_req(input logic [SEL_BITS-1:0] sel, input logic [WIDX_BITS-1:0] idx,
                                 input logic leaf, input logic [VALUE_BITS-1:0] val);
    send_req(KIND_WRITE, pack_req(rand_addr(), sel, idx, leaf, val));
  endtask

  task automatic lookup_req(input logic [ADDR_BITS-1:0] addr);
    send_req(KIND_LOOKUP, pack_req(addr, 3'($urandom), 16'($urandom), 1'($urandom),
                                   16'($urandom)));
  endtask

  // Fills every entry that the walk of addr still lacks, then looks addr up.
  task automatic routed_lookup(input logic [ADDR_BITS-1:0] addr);
    answer_t               ans;
    logic [LEVEL_BITS-1:0] lvl;
    logic [WIDX_BITS-1:0]  idx;
    logic                  leaf;
    logic [VALUE_BITS-1:0] val;
    while (!walk_trie(addr, ans, lvl, idx)) begin
      if (lvl == LVL_64) begin
        leaf = 1'($urandom);
        val = 16'($urandom);
      end else begin
        leaf = ($urandom_range(0, 3) == 0);
        if (leaf || $urandom_range(0, 9) == 0)
          val = 16'($urandom);
        else if (lvl == LVL_48)
          val = '0;
        else
          val = 16'($urandom_range(0, 255));
      end
      write_entry_req(lvl, idx, leaf, val);
    end
    lookup_req(addr);
  endtask

  task automatic wait_for_answers();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_level16_leaf();
    write_entry_req(LVL_16, 16'hFFFF, 1'b1, 16'hFFFF);
    lookup_req({16'hFFFF, 48'(rand_addr())});
    write_entry_req(LVL_16, 16'h0000, 1'b1, 16'h0000);
    lookup_req('0);
  endtask

  task automatic test_deep_walk();
    write_entry_req(LVL_16, 16'hFFFF, 1'b0, 16'h00FF);
    write_entry_req(LVL_24, 16'hFFFF, 1'b0, 16'h00FF);
    write_entry_req(LVL_32, 16'hFFFF, 1'b0, 16'h00FF);
    write_entry_req(LVL_40, 16'hFFFF, 1'b0, 16'h00FF);
    write_entry_req(LVL_48, 16'hFFFF, 1'b0, 16'h0000);
    write_entry_req(LVL_64, 16'hFFFF, 1'b1, 16'hABCD);
    lookup_req({ADDR_BITS{1'b1}});
    write_entry_req(LVL_40, 16'hFFFF, 1'b1, 16'h1234);
    lookup_req({ADDR_BITS{1'b1}});
  endtask

  task automatic test_index_error();
    write_entry_req(LVL_40, 16'hFFFF, 1'b0, 16'h00FF);
    write_entry_req(LVL_48, 16'hFFFF, 1'b0, 16'h0001);
    lookup_req({ADDR_BITS{1'b1}});
    write_entry_req(LVL_24, 16'hFFFF, 1'b0, 16'hFFFF);
    lookup_req({ADDR_BITS{1'b1}});
  endtask

  task automatic test_ignored_writes();
    write_entry_req(SEL_SPARE_A, 16'h0000, 1'b1, 16'h5555);
    write_entry_req(SEL_SPARE_B, 16'h0000, 1'b0, 16'hAAAA);
    lookup_req({16'h0000, 48'(rand_addr())});
  endtask

  // The receiver holds off while lookups keep coming, so the block backs up.
  task automatic test_output_stall();
    tx_idle_on = 1'b0;
    rx_stall_len = STALL_CYCLES;
    repeat (STALL_LOOKUPS) routed_lookup(pick_addr());
    wait_for_answers();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int step;
    int pick;
    step = 0;
    while (sent_items < ITEM_TARGET) begin
      if (step % 100 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (step == 300)
        wait_for_answers();
      pick = $urandom_range(0, 99);
      if (pick < 75)
        routed_lookup(pick_addr());
      else
        write_entry_req(3'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
      step++;
    end
  endtask

  initial begin
    int hold;
    wait (rst_ni);
    forever begin
      if (rx_stall_len > 0) begin
        hold = rx_stall_len;
        rx_stall_len = 0;
      end else if (rx_idle_on) begin
        hold = $urandom_range(0, MAX_IDLE);
      end else begin
        hold = 0;
      end
      repeat (hold) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    answer_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hop = m_axis_tdata[15:0];
      got.level = m_axis_tdata[18:16];
      got.err = m_axis_tuser;
      if (answer_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: hop %h level %0d err %b", got.hop, got.level, got.err);
      end else begin
        want = answer_q.pop_front();
        if (got != want || m_axis_tdata[OUT_DATA_BITS-1:19] != '0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display({"result differs: expected hop %h level %0d err %b, ",
                      "got hop %h level %0d err %b fill %h"},
                     want.hop, want.level, want.err, got.hop, got.level, got.err,
                     m_axis_tdata[OUT_DATA_BITS-1:19]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("multilevel_ipv6_prefix_lookup_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    addr_pool[0] = {ADDR_BITS{1'b1}};
    addr_pool[1] = '0;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_level16_leaf();
    test_deep_walk();
    test_index_error();
    test_ignored_writes();
    test_output_stall();
    test_random_traffic();
    wait_for_answers();

    if (mismatch_cnt == 0 && answer_q.size() == 0)
      $display("multilevel_ipv6_prefix_lookup_top: match");
    else
      $display("multilevel_ipv6_prefix_lookup_top: mismatch");
    $finish;
  end

endmodule
